// ===== rtl/core/keyed_table_insert_remove_search_macros.svh =====
// ----------------------------------------------------------------------------
// Keyed table assertion macros
// Shared concurrent assertion forms for the keyed table design.
// ----------------------------------------------------------------------------
`ifndef KEYED_TABLE_INSERT_REMOVE_SEARCH_MACROS_SVH
`define KEYED_TABLE_INSERT_REMOVE_SEARCH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyed table: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define KT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyed table: next-cycle check failed");

`endif

// ===== rtl/core/kt_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed table package
// Types, widths and codes shared by the keyed table modules.
// ----------------------------------------------------------------------------
package kt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = 7;
  localparam int KEY_W       = 32;
  localparam int HANDLE_W    = 16;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SEARCH = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED    = 3'd0,
    ST_DUPLICATE   = 3'd1,
    ST_FULL        = 3'd2,
    ST_REMOVED     = 3'd3,
    ST_REMOVE_MISS = 3'd4,
    ST_FOUND       = 3'd5,
    ST_NOT_FOUND   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DECIDE,
    FSM_SHIFT,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic signed [KEY_W-1:0] key;
    logic [HANDLE_W-1:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic re;
    logic [ADDR_W-1:0] raddr;
    logic we;
    logic [ADDR_W-1:0] waddr;
    entry_t wdata;
  } mem_req_t;

  typedef struct packed {
    logic valid;
    status_e status;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage

// ===== rtl/core/kt_ram.sv =====
// ----------------------------------------------------------------------------
// Keyed table RAM
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module kt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/kt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Keyed table sequencer
// Scans the table for a key, appends entries and closes gaps on removal.
// ----------------------------------------------------------------------------
module kt_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  output logic                    req_ready_o,
  input  kt_pkg::in_item_t        req_item_i,
  input  logic [kt_pkg::CNT_W-1:0] limit_i,
  output kt_pkg::mem_req_t        mem_o,
  input  kt_pkg::entry_t          rd_entry_i,
  output kt_pkg::result_t         res_o,
  input  logic                    res_ready_i
);
  import kt_pkg::*;

  fsm_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic [CNT_W-1:0] pidx_q, pidx_d;
  logic pend_q, pend_d;
  logic present_q, present_d;
  logic [ACTION_W-1:0] op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  status_e status_q, status_d;

  logic hit;
  logic last;
  logic ins_ok;
  logic shift_needed;
  logic [CNT_W-1:0] pidx_m1;

  assign hit          = pend_q && (rd_entry_i.key == key_q);
  assign last         = pend_q && ((pidx_q + CNT_W'(1)) == count_q);
  assign ins_ok       = !present_q && (count_q < limit_i);
  assign shift_needed = present_q && (scan_q < count_q);
  assign pidx_m1      = pidx_q - CNT_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (req_valid_i) begin
          state_d = (count_q == '0) ? FSM_DECIDE : FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (hit || last) begin
          state_d = FSM_DECIDE;
        end
      end
      FSM_DECIDE: begin
        if ((op_q == ACT_REMOVE) && shift_needed) begin
          state_d = FSM_SHIFT;
        end else begin
          state_d = FSM_DONE;
        end
      end
      FSM_SHIFT: begin
        if (last) begin
          state_d = FSM_DONE;
        end
      end
      FSM_DONE: begin
        if (res_ready_i) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    mem_o       = '0;
    mem_o.raddr = scan_q[ADDR_W-1:0];
    req_ready_o = 1'b0;
    res_o       = '0;
    case (state_q)
      FSM_IDLE: begin
        req_ready_o = 1'b1;
      end
      FSM_SCAN: begin
        mem_o.re = !hit && !last;
      end
      FSM_DECIDE: begin
        if ((op_q == ACT_INSERT) && ins_ok) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = count_q[ADDR_W-1:0];
          mem_o.wdata = '{key: key_q, handle: handle_q};
        end
      end
      FSM_SHIFT: begin
        mem_o.re    = !last;
        mem_o.we    = pend_q;
        mem_o.waddr = pidx_m1[ADDR_W-1:0];
        mem_o.wdata = rd_entry_i;
      end
      FSM_DONE: begin
        res_o.valid = 1'b1;
      end
      default: ;
    endcase
    res_o.status = status_q;
    res_o.count  = count_q;
  end

  always_comb begin
    count_d   = count_q;
    scan_d    = scan_q;
    pidx_d    = pidx_q;
    pend_d    = 1'b0;
    present_d = present_q;
    op_d      = op_q;
    key_d     = key_q;
    handle_d  = handle_q;
    status_d  = status_q;
    case (state_q)
      FSM_IDLE: begin
        op_d      = req_item_i.action;
        key_d     = req_item_i.key;
        handle_d  = req_item_i.handle;
        scan_d    = '0;
        present_d = 1'b0;
      end
      FSM_SCAN: begin
        if (hit) begin
          present_d = 1'b1;
          scan_d    = pidx_q + CNT_W'(1);
        end else if (!last) begin
          pend_d = 1'b1;
          pidx_d = scan_q;
          scan_d = scan_q + CNT_W'(1);
        end
      end
      FSM_DECIDE: begin
        case (op_q)
          ACT_INSERT: begin
            if (present_q) begin
              status_d = ST_DUPLICATE;
            end else if (ins_ok) begin
              status_d = ST_INSERTED;
              count_d  = count_q + CNT_W'(1);
            end else begin
              status_d = ST_FULL;
            end
          end
          ACT_REMOVE: begin
            if (present_q) begin
              status_d = ST_REMOVED;
              if (!shift_needed) begin
                count_d = count_q - CNT_W'(1);
              end
            end else begin
              status_d = ST_REMOVE_MISS;
            end
          end
          default: begin
            status_d = present_q ? ST_FOUND : ST_NOT_FOUND;
          end
        endcase
      end
      FSM_SHIFT: begin
        if (last) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          pend_d = 1'b1;
          pidx_d = scan_q;
          scan_d = scan_q + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q    <= scan_d;
    pidx_q    <= pidx_d;
    present_q <= present_d;
    op_q      <= op_d;
    key_q     <= key_d;
    handle_q  <= handle_d;
    status_q  <= status_d;
  end

endmodule

// ===== rtl/core/keyed_table_insert_remove_search.sv =====
// ----------------------------------------------------------------------------
// Keyed table with insert, remove and search
// Packed key/handle table in one synchronous RAM with a scanning sequencer.
// ----------------------------------------------------------------------------
//  Channel  | Signals                          | Meaning
//  ---------+----------------------------------+-------------------------------
//  in       | in_valid_i in_ready_o in_data_i  | action, key and handle
//  out      | out_valid_o out_ready_i out_data_o | status and entry count
//  cfg      | cfg_we_i cfg_wdata_i             | capacity register write
//
// The sequencer scans the held entries through the single RAM read port, one
// entry per cycle, and skips the scan on an empty table; a hit ends the scan
// early, and a removal that closes a gap then shifts the later entries down.
// Reset clears the count and capacity returns to 64; the RAM needs no
// clearing. A new transaction is taken while the previous result waits in the
// output register; the next result then waits in the sequencer and holds off
// the input.
module keyed_table_insert_remove_search (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  kt_pkg::in_item_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output kt_pkg::out_item_t        out_data_o,
  input  logic                     cfg_we_i,
  input  logic [kt_pkg::CNT_W-1:0] cfg_wdata_i
);
  import kt_pkg::*;

  `include "keyed_table_insert_remove_search_macros.svh"

  logic [CNT_W-1:0] cap_q;
  logic [CNT_W-1:0] limit;
  logic             out_valid_q;
  out_item_t        out_data_q;
  logic             res_ready;
  mem_req_t         mem_req;
  entry_t           rd_entry;
  result_t          res;
  logic [ENTRY_W-1:0] rdata;

  assign limit = (cap_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  kt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(mem_req.wdata),
    .re_i   (mem_req.re),
    .raddr_i(mem_req.raddr),
    .rdata_o(rdata)
  );

  assign rd_entry = entry_t'(rdata);

  kt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_ready_o(in_ready_o),
    .req_item_i (in_data_i),
    .limit_i    (limit),
    .mem_o      (mem_req),
    .rd_entry_i (rd_entry),
    .res_o      (res),
    .res_ready_i(res_ready)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_data_q.status      <= res.status;
      out_data_q.entry_count <= res.count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `KT_ASSERT_IMPLY(a_count_bounded, 1'b1, res.count <= CNT_W'(TABLE_DEPTH))
  `KT_ASSERT_NEXT(a_no_instant_result, in_valid_i && in_ready_o, !res.valid)
  `KT_ASSERT_NEXT(a_count_steps, 1'b1, (res.count == $past(res.count)) || (res.count == ($past(res.count) + CNT_W'(1))) || ((res.count + CNT_W'(1)) == $past(res.count)))

endmodule
